FILE: hdl/alias_table_sampler_top_assert.svh
// Assertion macros shared by the sampler modules.
// Each module that uses them needs clk and rst_n in scope.
`ifndef ALIAS_TABLE_SAMPLER_TOP_ASSERT_SVH
`define ALIAS_TABLE_SAMPLER_TOP_ASSERT_SVH

// Condition holds at every edge outside reset.
`define ATS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ATS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/ats_pkg.sv
// Shared constants, codes and structs of the alias table sampler.
// No dependencies.
package ats_pkg;

  localparam int MAX_BINS      = 64;
  localparam int WEIGHT_BITS   = 16;
  localparam int FRACTION_BITS = 16;

  localparam int BIN_W    = $clog2(MAX_BINS);
  localparam int CNT_W    = BIN_W + 1;
  localparam int TOTAL_W  = WEIGHT_BITS + BIN_W;
  localparam int SCALED_W = WEIGHT_BITS + 2 * BIN_W;
  localparam int CFG_W    = 7;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTBUILT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERLOAD = 3'd4;

  typedef struct packed {
    logic                   en;
    logic [BIN_W-1:0]       addr;
    logic [WEIGHT_BITS-1:0] data;
  } ld_wr_t;

  typedef struct packed {
    logic               en;
    logic [BIN_W-1:0]   addr;
    logic [TOTAL_W-1:0] thr;
    logic [BIN_W-1:0]   topup;
  } tbl_wr_t;

  typedef struct packed {
    logic done;
    logic zero;
  } bld_res_t;

endpackage

FILE: hdl/ats_build.sv
// Table build sequencer: owns the weight memory and the shared bin stack memory.
// Depends on ats_pkg and alias_table_sampler_top_assert.svh.
`include "alias_table_sampler_top_assert.svh"
module ats_build (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ats_pkg::CNT_W-1:0]   n,
  input  logic [ats_pkg::CNT_W-1:0]   load_pos,
  input  ats_pkg::ld_wr_t             ld_wr,
  output ats_pkg::tbl_wr_t            tbl_wr,
  output ats_pkg::bld_res_t           res,
  output logic [ats_pkg::TOTAL_W-1:0] total
);

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_SUM_RD = 4'd1;
  localparam logic [3:0] B_SUM_AC = 4'd2;
  localparam logic [3:0] B_SCL_RD = 4'd3;
  localparam logic [3:0] B_SCL_WR = 4'd4;
  localparam logic [3:0] B_PR_RD  = 4'd5;
  localparam logic [3:0] B_PR_SW  = 4'd6;
  localparam logic [3:0] B_PR_UP  = 4'd7;
  localparam logic [3:0] B_LO_RD  = 4'd8;
  localparam logic [3:0] B_LO_WR  = 4'd9;

  localparam int BW = ats_pkg::BIN_W;
  localparam int CW = ats_pkg::CNT_W;
  localparam int SW = ats_pkg::SCALED_W;
  localparam int TW = ats_pkg::TOTAL_W;
  localparam logic [CW-1:0] TOP_SLOT = CW'(ats_pkg::MAX_BINS);

  logic [SW-1:0] sw_mem [ats_pkg::MAX_BINS];
  logic [BW-1:0] stk_mem [ats_pkg::MAX_BINS];

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] ud_r, ud_nxt, od_r, od_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [BW-1:0] u_r, u_nxt, o_r, o_nxt;

  logic          sw_we;
  logic [BW-1:0] sw_wa, sw_ra0, sw_ra1;
  logic [SW-1:0] sw_wd, sw_q0, sw_q1;
  logic          stk_we;
  logic [BW-1:0] stk_wa, stk_wd, stk_ra0, stk_ra1, stk_q0, stk_q1;

  logic [TW-1:0] sum_v;
  logic [SW-1:0] scl_v, nw_v;
  logic [CW-1:0] ud_top, od_top, od_push;

  always_ff @(posedge clk) begin
    if (sw_we) begin
      sw_mem[sw_wa] <= sw_wd;
    end
    sw_q0 <= sw_mem[sw_ra0];
    sw_q1 <= sw_mem[sw_ra1];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q0 <= stk_mem[stk_ra0];
    stk_q1 <= stk_mem[stk_ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_IDLE;
      idx_r   <= '0;
      ud_r    <= '0;
      od_r    <= '0;
      total_r <= '0;
    end else begin
      st_r    <= st_nxt;
      idx_r   <= idx_nxt;
      ud_r    <= ud_nxt;
      od_r    <= od_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    o_r <= o_nxt;
  end

  // under bins grow up from slot 0, over bins grow down from the top slot
  assign ud_top  = ud_r - CW'(1);
  assign od_top  = TOP_SLOT - od_r;
  assign od_push = TOP_SLOT - od_r - CW'(1);

  assign sum_v = (idx_r < load_pos) ? TW'(sw_q0[ats_pkg::WEIGHT_BITS-1:0]) : '0;
  assign scl_v = ((idx_r < load_pos) ? SW'(sw_q0[ats_pkg::WEIGHT_BITS-1:0]) : '0) * SW'(n);
  assign nw_v  = sw_q1 + sw_q0 - SW'(total_r);

  always_comb begin
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    ud_nxt    = ud_r;
    od_nxt    = od_r;
    total_nxt = total_r;
    u_nxt     = u_r;
    o_nxt     = o_r;
    sw_we     = ld_wr.en;
    sw_wa     = ld_wr.addr;
    sw_wd     = SW'(ld_wr.data);
    sw_ra0    = idx_r[BW-1:0];
    sw_ra1    = idx_r[BW-1:0];
    stk_we    = 1'b0;
    stk_wa    = ud_r[BW-1:0];
    stk_wd    = idx_r[BW-1:0];
    stk_ra0   = ud_top[BW-1:0];
    stk_ra1   = od_top[BW-1:0];
    tbl_wr    = '0;
    res       = '0;
    case (st_r)
      B_IDLE: begin
        if (start) begin
          idx_nxt   = '0;
          ud_nxt    = '0;
          od_nxt    = '0;
          total_nxt = '0;
          st_nxt    = B_SUM_RD;
        end
      end
      B_SUM_RD: begin
        st_nxt = B_SUM_AC;
      end
      B_SUM_AC: begin
        total_nxt = total_r + sum_v;
        if (idx_r == n - CW'(1)) begin
          idx_nxt = '0;
          if (total_nxt == '0) begin
            res.done = 1'b1;
            res.zero = 1'b1;
            st_nxt   = B_IDLE;
          end else begin
            st_nxt = B_SCL_RD;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
          st_nxt  = B_SUM_RD;
        end
      end
      B_SCL_RD: begin
        st_nxt = B_SCL_WR;
      end
      B_SCL_WR: begin
        sw_we  = 1'b1;
        sw_wa  = idx_r[BW-1:0];
        sw_wd  = scl_v;
        stk_we = 1'b1;
        stk_wd = idx_r[BW-1:0];
        if (scl_v < SW'(total_r)) begin
          stk_wa = ud_r[BW-1:0];
          ud_nxt = ud_r + CW'(1);
        end else begin
          stk_wa = od_push[BW-1:0];
          od_nxt = od_r + CW'(1);
        end
        if (idx_r == n - CW'(1)) begin
          st_nxt = B_PR_RD;
        end else begin
          idx_nxt = idx_r + CW'(1);
          st_nxt  = B_SCL_RD;
        end
      end
      B_PR_RD: begin
        if (ud_r == '0 || od_r == '0) begin
          st_nxt = B_LO_RD;
        end else begin
          st_nxt = B_PR_SW;
        end
      end
      B_PR_SW: begin
        u_nxt  = stk_q0;
        o_nxt  = stk_q1;
        sw_ra0 = stk_q0;
        sw_ra1 = stk_q1;
        st_nxt = B_PR_UP;
      end
      B_PR_UP: begin
        tbl_wr.en    = 1'b1;
        tbl_wr.addr  = u_r;
        tbl_wr.thr   = sw_q0[TW-1:0];
        tbl_wr.topup = o_r;
        sw_we        = 1'b1;
        sw_wa        = o_r;
        sw_wd        = nw_v;
        stk_we       = 1'b1;
        stk_wd       = o_r;
        // pop both, then return the reduced over bin to its stack
        if (nw_v < SW'(total_r)) begin
          stk_wa = ud_top[BW-1:0];
          od_nxt = od_r - CW'(1);
        end else begin
          stk_wa = od_top[BW-1:0];
          ud_nxt = ud_r - CW'(1);
        end
        st_nxt = B_PR_RD;
      end
      B_LO_RD: begin
        if (od_r != '0) begin
          stk_ra0 = od_top[BW-1:0];
          st_nxt  = B_LO_WR;
        end else if (ud_r != '0) begin
          st_nxt = B_LO_WR;
        end else begin
          res.done = 1'b1;
          st_nxt   = B_IDLE;
        end
      end
      B_LO_WR: begin
        tbl_wr.en    = 1'b1;
        tbl_wr.addr  = stk_q0;
        tbl_wr.thr   = total_r;
        tbl_wr.topup = stk_q0;
        if (od_r != '0) begin
          od_nxt = od_r - CW'(1);
        end else begin
          ud_nxt = ud_r - CW'(1);
        end
        st_nxt = B_LO_RD;
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  assign total = total_r;

  `ATS_ASSERT_ALWAYS(a_stack_fits, (ud_r + od_r) <= CW'(ats_pkg::MAX_BINS), "stacks overlap")
  `ATS_ASSERT_IMPL(a_pair_nonempty, st_r == B_PR_SW || st_r == B_PR_UP, ud_r != '0 && od_r != '0, "pairing with an empty stack")
  `ATS_ASSERT_IMPL(a_done_empty, res.done && !res.zero, ud_r == '0 && od_r == '0, "build ended with bins on a stack")

endmodule

FILE: hdl/ats_draw.sv
// Draw unit: holds the threshold/topup memory and decides bin or topup.
// Depends on ats_pkg.
module ats_draw (
  input  logic                              clk,
  input  logic                              req,
  input  logic [ats_pkg::BIN_W-1:0]         die,
  input  logic [ats_pkg::FRACTION_BITS-1:0] coin,
  input  logic [ats_pkg::TOTAL_W-1:0]       total,
  input  ats_pkg::tbl_wr_t                  tbl_wr,
  output logic [ats_pkg::BIN_W-1:0]         chosen
);

  localparam int BW = ats_pkg::BIN_W;
  localparam int TW = ats_pkg::TOTAL_W;
  localparam int FB = ats_pkg::FRACTION_BITS;
  localparam int PW = TW + FB;

  logic [TW+BW-1:0] tbl_mem [ats_pkg::MAX_BINS];
  logic [TW+BW-1:0] tbl_q;
  logic [BW-1:0]    die_r;
  logic [FB-1:0]    coin_r;
  logic [PW-1:0]    lhs, rhs;

  always_ff @(posedge clk) begin
    if (tbl_wr.en) begin
      tbl_mem[tbl_wr.addr] <= {tbl_wr.thr, tbl_wr.topup};
    end
    tbl_q <= tbl_mem[die];
    if (req) begin
      die_r  <= die;
      coin_r <= coin;
    end
  end

  // keep the bin when coin * T < numerator * 2^FB
  assign lhs    = PW'(coin_r) * PW'(total);
  assign rhs    = {tbl_q[TW+BW-1:BW], {FB{1'b0}}};
  assign chosen = (lhs < rhs) ? die_r : tbl_q[BW-1:0];

endmodule

FILE: hdl/alias_table_sampler_top.sv
// Alias table sampler: a load writes one weight, a draw reads the table then compares,
// and a build scales the weights, pairs under and over bins and then fixes leftover bins,
// as the build sequencer walks the weight and stack memories one entry at a time.
// Loads run at one per cycle while results are taken; a draw or build closes the input until its
// result is registered. A waiting result holds the input until it transfers, and the input reopens in that same cycle.
// Reset (rst_n low, synchronous): control state cleared, bin count 64, no memory clear.
`include "alias_table_sampler_top_assert.svh"
module alias_table_sampler_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ats_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ats_pkg::CMD_W-1:0]            in_cmd,
  input  logic [ats_pkg::WEIGHT_BITS-1:0]      in_weight,
  input  logic [ats_pkg::BIN_W-1:0]            in_die_index,
  input  logic [ats_pkg::FRACTION_BITS-1:0]    in_coin_fraction,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ats_pkg::STATUS_W-1:0]         out_status,
  output logic [ats_pkg::BIN_W-1:0]            out_chosen_bin
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BUILD = 2'd1;
  localparam logic [1:0] ST_DRAW  = 2'd2;

  localparam int CW = ats_pkg::CNT_W;
  localparam int BW = ats_pkg::BIN_W;

  logic [1:0]                    st_r, st_nxt;
  logic [ats_pkg::CFG_W-1:0]     bc_r, bc_nxt;
  logic [CW-1:0]                 lp_r, lp_nxt;
  logic                          rdy_r, rdy_nxt;
  logic                          ov_r, ov_nxt;
  logic [ats_pkg::STATUS_W-1:0]  ost_r, ost_nxt;
  logic [BW-1:0]                 obin_r, obin_nxt;

  logic [CW-1:0]                 n;
  logic                          acc;
  logic                          bld_start, drw_req;
  ats_pkg::ld_wr_t               ld_wr;
  ats_pkg::tbl_wr_t              tbl_wr;
  ats_pkg::bld_res_t             bld_res;
  logic [ats_pkg::TOTAL_W-1:0]   total;
  logic [BW-1:0]                 drw_bin;

  // bins in use: zero counts as one, anything above the table size is clamped
  always_comb begin
    if (bc_r == '0) begin
      n = CW'(1);
    end else if (int'(bc_r) > ats_pkg::MAX_BINS) begin
      n = CW'(ats_pkg::MAX_BINS);
    end else begin
      n = CW'(bc_r);
    end
  end

  assign in_ready = (st_r == ST_IDLE) && (!ov_r || out_ready);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      bc_r  <= ats_pkg::CFG_W'(ats_pkg::MAX_BINS);
      lp_r  <= '0;
      rdy_r <= 1'b0;
      ov_r  <= 1'b0;
      ost_r <= ats_pkg::ST_OK;
    end else begin
      st_r  <= st_nxt;
      bc_r  <= bc_nxt;
      lp_r  <= lp_nxt;
      rdy_r <= rdy_nxt;
      ov_r  <= ov_nxt;
      ost_r <= ost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obin_r <= obin_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    bc_nxt    = bc_r;
    lp_nxt    = lp_r;
    rdy_nxt   = rdy_r;
    ov_nxt    = ov_r && !out_ready;
    ost_nxt   = ost_r;
    obin_nxt  = obin_r;
    bld_start = 1'b0;
    drw_req   = 1'b0;
    ld_wr     = '0;
    ld_wr.addr = lp_r[BW-1:0];
    ld_wr.data = in_weight;
    if (cfg_we) begin
      // a new bin count invalidates the table
      bc_nxt  = cfg_wdata;
      rdy_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          ov_nxt   = 1'b1;
          ost_nxt  = ats_pkg::ST_OK;
          obin_nxt = '0;
          case (in_cmd)
            ats_pkg::CMD_LOAD: begin
              if (lp_r >= n) begin
                ost_nxt = ats_pkg::ST_OVERLOAD;
              end else begin
                ld_wr.en = 1'b1;
                lp_nxt   = lp_r + CW'(1);
                rdy_nxt  = 1'b0;
              end
            end
            ats_pkg::CMD_BUILD: begin
              // hold the result until the sequencer finishes
              ov_nxt    = 1'b0;
              bld_start = 1'b1;
              rdy_nxt   = 1'b0;
              st_nxt    = ST_BUILD;
            end
            ats_pkg::CMD_DRAW: begin
              if (!rdy_r) begin
                ost_nxt = ats_pkg::ST_NOTBUILT;
              end else if (CW'(in_die_index) >= n) begin
                ost_nxt = ats_pkg::ST_RANGE;
              end else begin
                ov_nxt  = 1'b0;
                drw_req = 1'b1;
                st_nxt  = ST_DRAW;
              end
            end
            default: begin
              ost_nxt = ats_pkg::ST_OK;
            end
          endcase
        end
      end
      ST_BUILD: begin
        if (bld_res.done) begin
          ov_nxt  = 1'b1;
          ost_nxt = bld_res.zero ? ats_pkg::ST_ZERO : ats_pkg::ST_OK;
          lp_nxt  = '0;
          rdy_nxt = !bld_res.zero;
          st_nxt  = ST_IDLE;
        end
      end
      ST_DRAW: begin
        ov_nxt   = 1'b1;
        ost_nxt  = ats_pkg::ST_OK;
        obin_nxt = drw_bin;
        st_nxt   = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  ats_build u_build (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (bld_start),
    .n        (n),
    .load_pos (lp_r),
    .ld_wr    (ld_wr),
    .tbl_wr   (tbl_wr),
    .res      (bld_res),
    .total    (total)
  );

  ats_draw u_draw (
    .clk    (clk),
    .req    (drw_req),
    .die    (in_die_index),
    .coin   (in_coin_fraction),
    .total  (total),
    .tbl_wr (tbl_wr),
    .chosen (drw_bin)
  );

  assign out_valid      = ov_r;
  assign out_status     = ost_r;
  assign out_chosen_bin = obin_r;

  `ATS_ASSERT_IMPL(a_bin_in_use, ov_r && ost_r == ats_pkg::ST_OK, CW'(obin_r) < n, "drawn bin beyond bins in use")
  `ATS_ASSERT_IMPL(a_ready_total, rdy_r, total != '0, "table marked ready with zero total")
  `ATS_ASSERT_IMPL(a_done_in_build, bld_res.done, st_r == ST_BUILD, "build finished outside a build")

endmodule

FILE: sim/alias_table_checker.sv
// Checker for the alias table sampler: watches the configuration, input and result ports,
// predicts each result and compares it with what the block returns.
// Depends on ats_pkg.
module alias_table_checker
  import ats_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [WEIGHT_BITS-1:0]   in_weight,
  input  logic [BIN_W-1:0]         in_die_index,
  input  logic [FRACTION_BITS-1:0] in_coin_fraction,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic [BIN_W-1:0]         out_chosen_bin,
  output int unsigned              mismatches,
  output int unsigned              outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BIN_W-1:0]    bin;
  } outcome_t;

  outcome_t            outcomes_q[$];
  outcome_t            got;
  outcome_t            want;

  logic [CFG_W-1:0]    bin_count_r;
  logic [SCALED_W-1:0] bin_wt    [MAX_BINS];
  logic [TOTAL_W-1:0]  bin_thr   [MAX_BINS];
  logic [BIN_W-1:0]    bin_topup [MAX_BINS];
  int                  under_stk [MAX_BINS];
  int                  over_stk  [MAX_BINS];
  int                  under_top;
  int                  over_top;
  int                  load_pos;
  logic [TOTAL_W-1:0]  wt_total;
  logic                built;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int bins_used();
    if (bin_count_r == '0) return 1;
    if (bin_count_r > MAX_BINS) return MAX_BINS;
    return int'(bin_count_r);
  endfunction

  // Light bins go on the under stack, full or heavy ones on the over stack.
  function automatic void push_bin(int b);
    if (bin_wt[b] < SCALED_W'(wt_total)) begin
      if (under_top < MAX_BINS) begin
        under_stk[under_top] = b;
        under_top++;
      end
    end else begin
      if (over_top < MAX_BINS) begin
        over_stk[over_top] = b;
        over_top++;
      end
    end
  endfunction

  function automatic logic [STATUS_W-1:0] build_table();
    int                 n;
    int                 u;
    int                 o;
    logic [TOTAL_W-1:0] sum;
    n   = bins_used();
    sum = '0;
    for (int i = 0; i < n; i++) begin
      if (i >= load_pos) bin_wt[i] = '0;
      sum += TOTAL_W'(bin_wt[i]);
    end
    load_pos  = 0;
    wt_total  = sum;
    under_top = 0;
    over_top  = 0;
    if (sum == '0) begin
      built = 1'b0;
      return ST_ZERO;
    end
    for (int i = 0; i < n; i++) begin
      bin_wt[i] = bin_wt[i] * SCALED_W'(n);
      push_bin(i);
    end
    while (over_top > 0 && under_top > 0) begin
      under_top--;
      over_top--;
      u = under_stk[under_top];
      o = over_stk[over_top];
      bin_thr[u]   = TOTAL_W'(bin_wt[u]);
      bin_topup[u] = BIN_W'(o);
      bin_wt[o]    = bin_wt[o] - (SCALED_W'(wt_total) - bin_wt[u]);
      push_bin(o);
    end
    // leftovers become full bins pointing at themselves
    while (over_top > 0) begin
      over_top--;
      bin_thr[over_stk[over_top]]   = wt_total;
      bin_topup[over_stk[over_top]] = BIN_W'(over_stk[over_top]);
    end
    while (under_top > 0) begin
      under_top--;
      bin_thr[under_stk[under_top]]   = wt_total;
      bin_topup[under_stk[under_top]] = BIN_W'(under_stk[under_top]);
    end
    built = 1'b1;
    return ST_OK;
  endfunction

  function automatic outcome_t predict_outcome(logic [CMD_W-1:0] cmd,
                                               logic [WEIGHT_BITS-1:0] w,
                                               logic [BIN_W-1:0] die,
                                               logic [FRACTION_BITS-1:0] coin);
    outcome_t                            r;
    logic [TOTAL_W+FRACTION_BITS-1:0]    lhs;
    logic [TOTAL_W+FRACTION_BITS-1:0]    rhs;
    r.status = ST_OK;
    r.bin    = '0;
    case (cmd)
      CMD_LOAD: begin
        if (load_pos >= bins_used()) begin
          r.status = ST_OVERLOAD;
        end else begin
          bin_wt[load_pos] = SCALED_W'(w);
          load_pos++;
          built = 1'b0;
        end
      end
      CMD_BUILD: r.status = build_table();
      CMD_DRAW: begin
        if (!built) begin
          r.status = ST_NOTBUILT;
        end else if (int'(die) >= bins_used()) begin
          r.status = ST_RANGE;
        end else begin
          lhs   = coin * wt_total;
          rhs   = {bin_thr[die], {FRACTION_BITS{1'b0}}};
          r.bin = (lhs < rhs) ? die : bin_topup[die];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void flag(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] checker: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r = CFG_W'(MAX_BINS);
      under_top   = 0;
      over_top    = 0;
      load_pos    = 0;
      wt_total    = '0;
      built       = 1'b0;
      outcomes_q.delete();
    end else begin
      if (cfg_we) begin
        bin_count_r = cfg_wdata;
        built       = 1'b0;
      end
      if (in_valid && in_ready)
        outcomes_q.push_back(predict_outcome(in_cmd, in_weight, in_die_index,
                                             in_coin_fraction));
      if (out_valid && out_ready) begin
        got.status = out_status;
        got.bin    = out_chosen_bin;
        if (outcomes_q.size() == 0) begin
          flag($sformatf("unexpected result status %0d bin %0d", got.status, got.bin));
        end else begin
          want = outcomes_q.pop_front();
          if (got.status !== want.status)
            flag($sformatf("status expected %0d actual %0d", want.status, got.status));
          if (got.bin !== want.bin)
            flag($sformatf("chosen_bin expected %0d actual %0d", want.bin, got.bin));
        end
      end
    end
    outstanding = outcomes_q.size();
  end

endmodule

FILE: sim/tb_alias_table_sampler_top.sv
// Testbench top for the alias table sampler: drives configuration and commands with
// bursty traffic and a stalling receiver, and gives the verdict.
// Depends on ats_pkg, alias_table_sampler_top and alias_table_checker.
module tb_alias_table_sampler_top;
  import ats_pkg::*;

  // spare command code, answered with an OK status and bin 0
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int ITEM_TARGET    = 1100;
  localparam int IDLE_LIMIT     = 5000;

  logic                     clk              = 1'b0;
  logic                     rst_n            = 1'b0;
  logic                     cfg_we           = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata        = '0;
  logic                     in_valid         = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd           = CMD_LOAD;
  logic [WEIGHT_BITS-1:0]   in_weight        = '0;
  logic [BIN_W-1:0]         in_die_index     = '0;
  logic [FRACTION_BITS-1:0] in_coin_fraction = '0;
  logic                     out_valid;
  logic                     out_ready        = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic [BIN_W-1:0]         out_chosen_bin;

  int unsigned mismatches;
  int unsigned outstanding;
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [9:0]  stall_phase = '0;

  always #6 clk = ~clk;

  alias_table_sampler_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_weight        (in_weight),
    .in_die_index     (in_die_index),
    .in_coin_fraction (in_coin_fraction),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_chosen_bin   (out_chosen_bin)
  );

  alias_table_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_weight        (in_weight),
    .in_die_index     (in_die_index),
    .in_coin_fraction (in_coin_fraction),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_chosen_bin   (out_chosen_bin),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Receiver: cycle through four stall moods - always ready, coin toss,
  // mostly stalled, and alternate cycles - so back-pressure hits every phase.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_phase[0];
    endcase
  end

  // Watchdog: end the run when nothing transfers on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Present one command and hold it until the transfer. Open a new burst after a
  // random gap when the current one runs out; valid is never dropped mid-burst.
  task automatic send(logic [CMD_W-1:0] cmd, logic [WEIGHT_BITS-1:0] w,
                      logic [BIN_W-1:0] die, logic [FRACTION_BITS-1:0] coin);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 12);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_weight        <= w;
    in_die_index     <= die;
    in_coin_fraction <= coin;
    burst_left--;
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every expected result has arrived, then settle.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_bin_count(logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [WEIGHT_BITS-1:0] pick_weight(int mode);
    case (mode)
      0:       return '0;
      1:       return WEIGHT_BITS'($urandom_range(0, 7));
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return WEIGHT_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [FRACTION_BITS-1:0] pick_coin();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return FRACTION_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] any_weight();
    return WEIGHT_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic logic [BIN_W-1:0] any_die(int hi);
    return BIN_W'($urandom_range(0, hi));
  endfunction

  initial begin
    int                 n;
    int                 loads;
    int                 draws;
    int                 mode;
    int                 r;
    logic [CFG_W-1:0]   cfg_v;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default 64 bins. Draw before any build, build with nothing
    // loaded (zero total), spare command, then a sparse table at the extremes.
    send(CMD_DRAW, '0, 6'd5, 16'h1234);
    send(CMD_BUILD, '1, '0, '0);
    send(CMD_SPARE, '1, '1, '1);
    send(CMD_LOAD, 16'hFFFF, '0, '0);
    send(CMD_LOAD, 16'h0000, '0, '0);
    send(CMD_LOAD, 16'h0001, '0, '0);
    send(CMD_BUILD, '0, '0, '0);
    send(CMD_DRAW, '0, 6'd0, 16'h0000);
    send(CMD_DRAW, '0, 6'd63, 16'hFFFF);
    send(CMD_DRAW, '0, 6'd1, 16'h8000);
    send(CMD_DRAW, '0, 6'd2, 16'hFFFF);
    drain();

    // Two bins: overload on the third load, index out of range on draws.
    write_bin_count(7'd2);
    send(CMD_LOAD, 16'd3, '0, '0);
    send(CMD_LOAD, 16'd1, '0, '0);
    send(CMD_LOAD, 16'd9, '0, '0);
    send(CMD_BUILD, '0, '0, '0);
    send(CMD_DRAW, '0, 6'd2, 16'h0000);
    send(CMD_DRAW, '0, 6'd63, 16'h0000);
    send(CMD_DRAW, '0, 6'd1, 16'hFFFF);
    send(CMD_DRAW, '0, 6'd0, 16'hC000);
    drain();

    // Zero written to the count behaves as a single bin.
    write_bin_count(7'd0);
    send(CMD_LOAD, 16'd7, '0, '0);
    send(CMD_BUILD, '0, '0, '0);
    send(CMD_DRAW, '0, 6'd0, 16'hFFFF);
    send(CMD_DRAW, '0, 6'd1, 16'h0000);

    // Random: one table per phase, loads mostly matching the bin count, then
    // a run of draws with some noise mixed in.
    while (items_sent < ITEM_TARGET) begin
      drain();
      r = $urandom_range(0, 9);
      case (r)
        0:       cfg_v = 7'd0;
        1:       cfg_v = 7'd127;
        2:       cfg_v = 7'd64;
        3:       cfg_v = 7'd1;
        4, 5, 6: cfg_v = CFG_W'($urandom_range(2, 8));
        default: cfg_v = CFG_W'($urandom_range(1, 64));
      endcase
      write_bin_count(cfg_v);
      n = (cfg_v == 0) ? 1 : (cfg_v > MAX_BINS) ? MAX_BINS : int'(cfg_v);
      loads = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n + 2) : n;
      mode  = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 5);
      for (int i = 0; i < loads; i++)
        send(CMD_LOAD, pick_weight(mode), any_die(63), pick_coin());
      send(CMD_BUILD, any_weight(), any_die(63), pick_coin());
      draws = $urandom_range(10, 60);
      for (int i = 0; i < draws; i++) begin
        r = $urandom_range(0, 29);
        case (r)
          0: send(CMD_SPARE, any_weight(), any_die(63), pick_coin());
          1: send(CMD_LOAD, pick_weight(mode), any_die(63), pick_coin());
          2: send(CMD_BUILD, any_weight(), any_die(63), pick_coin());
          3, 4: send(CMD_DRAW, any_weight(), any_die(63), pick_coin());
          default:
            send(CMD_DRAW, any_weight(), any_die(n - 1), pick_coin());
        endcase
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ats_pkg.sv
hdl/ats_build.sv
hdl/ats_draw.sv
hdl/alias_table_sampler_top.sv
sim/alias_table_checker.sv
sim/tb_alias_table_sampler_top.sv
